@@ design/wrd_pkg.sv @@
// Shared types and constants for the weather record decoder.
`default_nettype none

package wrd_pkg;

  localparam int StoreDepth = 16;
  localparam int AddrW      = $clog2(StoreDepth);

  typedef logic [1:0] result_code_t;

  localparam result_code_t RcOk      = 2'd0;
  localparam result_code_t RcLost    = 2'd1;
  localparam result_code_t RcInvalid = 2'd2;

  localparam logic [7:0]  ByteMarker = 8'hFF;
  localparam logic [15:0] WordMarker = 16'hFFFF;
  localparam logic [3:0]  NibMarker  = 4'hF;
  localparam int          LostBit    = 6;

  typedef struct packed {
    logic             wr_en;
    logic [AddrW-1:0] wr_addr;
    logic             decode;
  } dp_cmd_t;

endpackage

`default_nettype wire

@@ design/weather_record_decoder.sv @@
// Top level of the weather record decoder.
//
// Takes one record byte per cycle while busy is low and keeps the first sixteen bytes.
// An item with in_last_byte set closes the record: busy is high for the next cycle
// while the result register loads from the byte store, and the decoded result shows
// on the out_ ports, marked by out_valid, for exactly one cycle once the load is done.
// No byte is taken during that load. The receiver cannot stall; every result must
// be taken in its cycle. Bytes past the sixteenth are not stored, and the byte
// position stops at RECORD_BYTES; a short record decodes whatever the store still
// holds.
`default_nettype none

module weather_record_decoder #(
  parameter int RECORD_BYTES = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic [7:0]            in_data_byte,
  input  wire logic                  in_last_byte,
  output logic                       out_valid,
  output logic [1:0]                 out_result_code,
  output logic [7:0]                 out_minutes_delay,
  output logic [7:0]                 out_indoor_humidity,
  output logic signed [15:0]         out_indoor_temp,
  output logic [7:0]                 out_outdoor_humidity,
  output logic signed [15:0]         out_outdoor_temp,
  output logic [15:0]                out_pressure_tenths,
  output logic [11:0]                out_wind_average,
  output logic [11:0]                out_wind_gust,
  output logic [6:0]                 out_wind_heading,
  output logic [15:0]                out_rain_count,
  output logic [7:0]                 out_status_bits
);

  wrd_pkg::dp_cmd_t cmd;

  wrd_ctrl #(
    .RECORD_BYTES (RECORD_BYTES)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .last_byte (in_last_byte),
    .busy      (busy),
    .cmd       (cmd)
  );

  wrd_datapath u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .data_byte        (in_data_byte),
    .out_valid        (out_valid),
    .result_code      (out_result_code),
    .minutes_delay    (out_minutes_delay),
    .indoor_humidity  (out_indoor_humidity),
    .indoor_temp      (out_indoor_temp),
    .outdoor_humidity (out_outdoor_humidity),
    .outdoor_temp     (out_outdoor_temp),
    .pressure_tenths  (out_pressure_tenths),
    .wind_average     (out_wind_average),
    .wind_gust        (out_wind_gust),
    .wind_heading     (out_wind_heading),
    .rain_count       (out_rain_count),
    .status_bits      (out_status_bits)
  );

endmodule

`default_nettype wire

@@ design/wrd_ctrl.sv @@
// Controller: byte position counter and collect/decode sequencing.
`default_nettype none

module wrd_ctrl #(
  parameter int RECORD_BYTES = 16
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic              last_byte,
  output logic                   busy,
  output wrd_pkg::dp_cmd_t       cmd
);

  localparam int PosW = $clog2(RECORD_BYTES + 1);

  typedef enum logic {
    ST_COLLECT,
    ST_DECODE
  } state_t;

  state_t            state_r, state_nxt;
  logic [PosW-1:0]   pos_r, pos_nxt;
  logic              busy_r, busy_nxt;
  logic              dec_r, dec_nxt;
  logic              accept;

  assign accept = start && !busy_r;

  always_comb begin
    state_nxt = state_r;
    pos_nxt   = pos_r;
    busy_nxt  = 1'b0;
    dec_nxt   = 1'b0;
    case (state_r)
      ST_COLLECT: begin
        if (accept) begin
          if (last_byte) begin
            pos_nxt   = '0;
            state_nxt = ST_DECODE;
            busy_nxt  = 1'b1;
            dec_nxt   = 1'b1;
          end else if (pos_r < PosW'(RECORD_BYTES)) begin
            pos_nxt = pos_r + PosW'(1);
          end
        end
      end
      ST_DECODE: begin
        state_nxt = ST_COLLECT;
      end
      default: begin
        state_nxt = ST_COLLECT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_COLLECT;
      pos_r   <= '0;
      busy_r  <= 1'b0;
      dec_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pos_r   <= pos_nxt;
      busy_r  <= busy_nxt;
      dec_r   <= dec_nxt;
    end
  end

  assign busy        = busy_r;
  assign cmd.wr_en   = accept && (pos_r < PosW'(wrd_pkg::StoreDepth));
  assign cmd.wr_addr = pos_r[wrd_pkg::AddrW-1:0];
  assign cmd.decode  = dec_r;

endmodule

`default_nettype wire

@@ design/wrd_datapath.sv @@
// Datapath: record byte store, field extraction and result register.
`default_nettype none

module wrd_datapath (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire wrd_pkg::dp_cmd_t       cmd,
  input  wire logic [7:0]             data_byte,
  output logic                        out_valid,
  output wrd_pkg::result_code_t       result_code,
  output logic [7:0]                  minutes_delay,
  output logic [7:0]                  indoor_humidity,
  output logic signed [15:0]          indoor_temp,
  output logic [7:0]                  outdoor_humidity,
  output logic signed [15:0]          outdoor_temp,
  output logic [15:0]                 pressure_tenths,
  output logic [11:0]                 wind_average,
  output logic [11:0]                 wind_gust,
  output logic [6:0]                  wind_heading,
  output logic [15:0]                 rain_count,
  output logic [7:0]                  status_bits
);

  logic [7:0] store_r [wrd_pkg::StoreDepth];

  logic                  valid_r;
  wrd_pkg::result_code_t code_r, code_nxt;
  logic [7:0]            delay_r, in_hum_r, out_hum_r, status_r;
  logic [15:0]           in_temp_r, out_temp_r, press_r, rain_r;
  logic [15:0]           in_temp_nxt, out_temp_nxt, press_nxt, rain_nxt;
  logic [11:0]           wavg_r, wgust_r, wavg_nxt, wgust_nxt;
  logic [6:0]            head_r;
  logic [15:0]           in_raw, out_raw;
  logic                  bad;

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      store_r[cmd.wr_addr] <= data_byte;
    end
  end

  always_comb begin
    in_raw    = {store_r[3], store_r[2]};
    out_raw   = {store_r[6], store_r[5]};
    press_nxt = {store_r[8], store_r[7]};
    rain_nxt  = {store_r[14], store_r[13]};
    wavg_nxt  = {store_r[11][3:0], store_r[9]};
    wgust_nxt = {store_r[11][7:4], store_r[10]};

    in_temp_nxt  = in_raw[15] ? 16'(16'd0 - {1'b0, in_raw[14:0]}) : {1'b0, in_raw[14:0]};
    out_temp_nxt = out_raw[15] ? 16'(16'd0 - {1'b0, out_raw[14:0]}) : {1'b0, out_raw[14:0]};

    bad = (store_r[0] == wrd_pkg::ByteMarker) || (store_r[1] == wrd_pkg::ByteMarker)
       || (store_r[4] == wrd_pkg::ByteMarker)
       || (in_raw == wrd_pkg::WordMarker) || (out_raw == wrd_pkg::WordMarker)
       || (press_nxt == wrd_pkg::WordMarker) || (rain_nxt == wrd_pkg::WordMarker)
       || ((store_r[9] == wrd_pkg::ByteMarker) && (store_r[11][3:0] == wrd_pkg::NibMarker))
       || ((store_r[10] == wrd_pkg::ByteMarker) && (store_r[11][7:4] == wrd_pkg::NibMarker))
       || store_r[12][7];

    if (store_r[15][wrd_pkg::LostBit]) begin
      code_nxt = wrd_pkg::RcLost;
    end else if (bad) begin
      code_nxt = wrd_pkg::RcInvalid;
    end else begin
      code_nxt = wrd_pkg::RcOk;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= cmd.decode;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.decode) begin
      code_r     <= code_nxt;
      delay_r    <= store_r[0];
      in_hum_r   <= store_r[1];
      in_temp_r  <= in_temp_nxt;
      out_hum_r  <= store_r[4];
      out_temp_r <= out_temp_nxt;
      press_r    <= press_nxt;
      wavg_r     <= wavg_nxt;
      wgust_r    <= wgust_nxt;
      head_r     <= store_r[12][6:0];
      rain_r     <= rain_nxt;
      status_r   <= store_r[15];
    end
  end

  assign out_valid        = valid_r;
  assign result_code      = code_r;
  assign minutes_delay    = delay_r;
  assign indoor_humidity  = in_hum_r;
  assign indoor_temp      = $signed(in_temp_r);
  assign outdoor_humidity = out_hum_r;
  assign outdoor_temp     = $signed(out_temp_r);
  assign pressure_tenths  = press_r;
  assign wind_average     = wavg_r;
  assign wind_gust        = wgust_r;
  assign wind_heading     = head_r;
  assign rain_count       = rain_r;
  assign status_bits      = status_r;

endmodule

`default_nettype wire

@@ design/wrd_checker.sv @@
// Port-level checks for the weather record decoder, bound to the top level.
`default_nettype none

module wrd_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        start,
  input wire logic        busy,
  input wire logic        in_last_byte,
  input wire logic        out_valid,
  input wire logic [1:0]  out_result_code,
  input wire logic [7:0]  out_status_bits
);

  a_last_sets_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_last_byte |=> busy)
    else $error("busy not raised after last byte");

  a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_last_byte |-> ##2 out_valid)
    else $error("no result two cycles after last byte");

  a_result_follows_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result without a preceding decode cycle");

  a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_result_code == wrd_pkg::RcOk) || (out_result_code == wrd_pkg::RcLost)
                  || (out_result_code == wrd_pkg::RcInvalid))
    else $error("result code out of range");

  a_lost_priority: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status_bits[wrd_pkg::LostBit] |-> out_result_code == wrd_pkg::RcLost)
    else $error("contact lost not reported");

endmodule

bind weather_record_decoder wrd_checker u_wrd_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .in_last_byte    (in_last_byte),
  .out_valid       (out_valid),
  .out_result_code (out_result_code),
  .out_status_bits (out_status_bits)
);

`default_nettype wire

@@ bench/wrd_checker.sv @@
// Checker for the weather record decoder: predicts each decoded record and compares it.
module wrd_scoreboard #(
  parameter int RECORD_BYTES = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               busy,
  input  logic [7:0]         in_data_byte,
  input  logic               in_last_byte,
  input  logic               out_valid,
  input  logic [1:0]         out_result_code,
  input  logic [7:0]         out_minutes_delay,
  input  logic [7:0]         out_indoor_humidity,
  input  logic signed [15:0] out_indoor_temp,
  input  logic [7:0]         out_outdoor_humidity,
  input  logic signed [15:0] out_outdoor_temp,
  input  logic [15:0]        out_pressure_tenths,
  input  logic [11:0]        out_wind_average,
  input  logic [11:0]        out_wind_gust,
  input  logic [6:0]         out_wind_heading,
  input  logic [15:0]        out_rain_count,
  input  logic [7:0]         out_status_bits,
  output int                 fail_count,
  output int                 outstanding
);

  typedef struct packed {
    wrd_pkg::result_code_t code;
    logic [7:0]         delay;
    logic [7:0]         in_hum;
    logic signed [15:0] in_temp;
    logic [7:0]         out_hum;
    logic signed [15:0] out_temp;
    logic [15:0]        pressure;
    logic [11:0]        wind_avg;
    logic [11:0]        wind_gust;
    logic [6:0]         heading;
    logic [15:0]        rain;
    logic [7:0]         status;
  } weather_rec_t;

  logic [7:0]   kept_bytes [wrd_pkg::StoreDepth];
  int           fill_pos = 0;
  int           mismatches = 0;
  weather_rec_t decoded_q [$];

  function automatic logic signed [15:0] sign_mag_temp(input logic [15:0] raw);
    logic [15:0] mag;
    mag = {1'b0, raw[14:0]};
    return raw[15] ? -mag : mag;
  endfunction

  function automatic weather_rec_t decode_record();
    weather_rec_t d;
    logic         bad;
    logic [15:0]  pres;
    logic [15:0]  rain;
    pres = {kept_bytes[8], kept_bytes[7]};
    rain = {kept_bytes[14], kept_bytes[13]};
    bad = (kept_bytes[0] == wrd_pkg::ByteMarker) || (kept_bytes[1] == wrd_pkg::ByteMarker) ||
          (kept_bytes[4] == wrd_pkg::ByteMarker) ||
          ({kept_bytes[3], kept_bytes[2]} == wrd_pkg::WordMarker) ||
          ({kept_bytes[6], kept_bytes[5]} == wrd_pkg::WordMarker) ||
          (pres == wrd_pkg::WordMarker) || (rain == wrd_pkg::WordMarker) ||
          (kept_bytes[9] == wrd_pkg::ByteMarker &&
           kept_bytes[11][3:0] == wrd_pkg::NibMarker) ||
          (kept_bytes[10] == wrd_pkg::ByteMarker &&
           kept_bytes[11][7:4] == wrd_pkg::NibMarker) ||
          kept_bytes[12][7];
    if (kept_bytes[15][wrd_pkg::LostBit]) begin
      d.code = wrd_pkg::RcLost;
    end else if (bad) begin
      d.code = wrd_pkg::RcInvalid;
    end else begin
      d.code = wrd_pkg::RcOk;
    end
    d.delay     = kept_bytes[0];
    d.in_hum    = kept_bytes[1];
    d.in_temp   = sign_mag_temp({kept_bytes[3], kept_bytes[2]});
    d.out_hum   = kept_bytes[4];
    d.out_temp  = sign_mag_temp({kept_bytes[6], kept_bytes[5]});
    d.pressure  = pres;
    d.wind_avg  = {kept_bytes[11][3:0], kept_bytes[9]};
    d.wind_gust = {kept_bytes[11][7:4], kept_bytes[10]};
    d.heading   = kept_bytes[12][6:0];
    d.rain      = rain;
    d.status    = kept_bytes[15];
    return d;
  endfunction

  task automatic show_record(input string tag, input weather_rec_t r);
    $display("  %s code=%0d dly=%h ih=%h it=%h oh=%h ot=%h p=%h wa=%h wg=%h hd=%h rn=%h st=%h",
             tag, r.code, r.delay, r.in_hum, r.in_temp, r.out_hum, r.out_temp, r.pressure,
             r.wind_avg, r.wind_gust, r.heading, r.rain, r.status);
  endtask

  always @(posedge clk) begin
    weather_rec_t got;
    weather_rec_t want;
    if (!rst_n) begin
      fill_pos = 0;
      decoded_q.delete();
    end else begin
      if (out_valid) begin
        got = {out_result_code, out_minutes_delay, out_indoor_humidity, out_indoor_temp,
               out_outdoor_humidity, out_outdoor_temp, out_pressure_tenths, out_wind_average,
               out_wind_gust, out_wind_heading, out_rain_count, out_status_bits};
        if (decoded_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("unexpected result at %0t", $realtime);
            show_record("act", got);
          end
        end else begin
          want = decoded_q.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("result mismatch at %0t", $realtime);
              show_record("exp", want);
              show_record("act", got);
            end
          end
        end
      end
      if (start && !busy) begin
        if (fill_pos < wrd_pkg::StoreDepth) begin
          kept_bytes[fill_pos] = in_data_byte;
        end
        if (fill_pos < RECORD_BYTES) begin
          fill_pos++;
        end
        if (in_last_byte) begin
          decoded_q.push_back(decode_record());
          fill_pos = 0;
        end
      end
    end
    fail_count  <= mismatches;
    outstanding <= decoded_q.size();
  end

endmodule

@@ bench/tb_weather_record_decoder.sv @@
// Testbench top for the weather record decoder: drives record bytes and reports the verdict.
module tb_weather_record_decoder;

  localparam int RECORD_BYTES = 16;
  localparam int RandomItems  = 1550;
  localparam int CycleLimit   = 200000;

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic [7:0]         in_data_byte;
  logic               in_last_byte;
  logic               out_valid;
  logic [1:0]         out_result_code;
  logic [7:0]         out_minutes_delay;
  logic [7:0]         out_indoor_humidity;
  logic signed [15:0] out_indoor_temp;
  logic [7:0]         out_outdoor_humidity;
  logic signed [15:0] out_outdoor_temp;
  logic [15:0]        out_pressure_tenths;
  logic [11:0]        out_wind_average;
  logic [11:0]        out_wind_gust;
  logic [6:0]         out_wind_heading;
  logic [15:0]        out_rain_count;
  logic [7:0]         out_status_bits;
  int                 fail_count;
  int                 outstanding;

  int                 cycles = 0;
  int                 sent = 0;
  logic [7:0]         rec_buf [0:31];
  int                 rec_len;

  weather_record_decoder #(.RECORD_BYTES(RECORD_BYTES)) uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_data_byte(in_data_byte), .in_last_byte(in_last_byte),
    .out_valid(out_valid), .out_result_code(out_result_code),
    .out_minutes_delay(out_minutes_delay), .out_indoor_humidity(out_indoor_humidity),
    .out_indoor_temp(out_indoor_temp), .out_outdoor_humidity(out_outdoor_humidity),
    .out_outdoor_temp(out_outdoor_temp), .out_pressure_tenths(out_pressure_tenths),
    .out_wind_average(out_wind_average), .out_wind_gust(out_wind_gust),
    .out_wind_heading(out_wind_heading), .out_rain_count(out_rain_count),
    .out_status_bits(out_status_bits)
  );

  wrd_scoreboard #(.RECORD_BYTES(RECORD_BYTES)) u_scoreboard (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_data_byte(in_data_byte), .in_last_byte(in_last_byte),
    .out_valid(out_valid), .out_result_code(out_result_code),
    .out_minutes_delay(out_minutes_delay), .out_indoor_humidity(out_indoor_humidity),
    .out_indoor_temp(out_indoor_temp), .out_outdoor_humidity(out_outdoor_humidity),
    .out_outdoor_temp(out_outdoor_temp), .out_pressure_tenths(out_pressure_tenths),
    .out_wind_average(out_wind_average), .out_wind_gust(out_wind_gust),
    .out_wind_heading(out_wind_heading), .out_rain_count(out_rain_count),
    .out_status_bits(out_status_bits), .fail_count(fail_count), .outstanding(outstanding)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    in_data_byte <= b;
    in_last_byte <= last;
    start        <= 1'b1;
    do @(posedge clk); while (busy);
    sent++;
  endtask

  task automatic send_record();
    bit quiet;
    for (int i = 0; i < rec_len; i++) begin
      send_byte(rec_buf[i], i == rec_len - 1);
      quiet = (sent >= 400 && sent < 800);
      if (!quiet && $urandom_range(0, 99) < 6) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk);
      end
    end
  endtask

  task automatic send_vector(input logic [255:0] bytes_le, input int len);
    for (int i = 0; i < len; i++) begin
      rec_buf[i] = bytes_le[8*i +: 8];
    end
    rec_len = len;
    send_record();
  endtask

  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic make_random_record();
    int kind;
    int pick;
    kind = $urandom_range(0, 99);
    if (kind < 72) begin
      rec_len = 16;
    end else if (kind < 86) begin
      rec_len = $urandom_range(1, 15);
    end else begin
      rec_len = $urandom_range(17, 24);
    end
    for (int i = 0; i < 32; i++) begin
      pick = $urandom_range(0, 9);
      case (pick)
        0:       rec_buf[i] = 8'hFF;
        1:       rec_buf[i] = 8'h00;
        2:       rec_buf[i] = 8'h80;
        default: rec_buf[i] = 8'($urandom);
      endcase
    end
    if ($urandom_range(0, 9) < 7) begin
      rec_buf[12][7] = 1'b0;
    end
    if ($urandom_range(0, 9) < 7) begin
      rec_buf[15][wrd_pkg::LostBit] = 1'b0;
    end
    if ($urandom_range(0, 9) == 0) begin
      rec_buf[2] = 8'h00;
      rec_buf[3] = 8'h80;
    end
    if ($urandom_range(0, 9) == 0) begin
      rec_buf[5] = 8'h00;
      rec_buf[6] = 8'h80;
    end
    if ($urandom_range(0, 9) < 3) begin
      case ($urandom_range(0, 9))
        0: rec_buf[0] = wrd_pkg::ByteMarker;
        1: rec_buf[1] = wrd_pkg::ByteMarker;
        2: rec_buf[4] = wrd_pkg::ByteMarker;
        3: {rec_buf[3], rec_buf[2]} = wrd_pkg::WordMarker;
        4: {rec_buf[6], rec_buf[5]} = wrd_pkg::WordMarker;
        5: {rec_buf[8], rec_buf[7]} = wrd_pkg::WordMarker;
        6: {rec_buf[14], rec_buf[13]} = wrd_pkg::WordMarker;
        7: begin
          rec_buf[9]       = wrd_pkg::ByteMarker;
          rec_buf[11][3:0] = wrd_pkg::NibMarker;
        end
        8: begin
          rec_buf[10]      = wrd_pkg::ByteMarker;
          rec_buf[11][7:4] = wrd_pkg::NibMarker;
        end
        default: rec_buf[12][7] = 1'b1;
      endcase
    end
  endtask

  initial begin
    bit paused;
    paused       = 1'b0;
    rst_n        <= 1'b0;
    start        <= 1'b0;
    in_data_byte <= 8'h00;
    in_last_byte <= 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_vector(256'hBFFFFE7F_EEFFFFFF_FE8000FE_7FFFFEFE, 16);
    send_vector(256'({128{1'b1}}), 16);
    send_vector(256'hFFFFFFFF_00000080_00000000_00000000_00000000, 20);
    send_vector(256'h3C, 1);

    while (sent < RandomItems) begin
      make_random_record();
      send_record();
      if (!paused && sent > RandomItems / 2) begin
        drain_results();
        paused = 1'b1;
      end
    end

    drain_results();
    repeat (6) @(posedge clk);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
design/wrd_pkg.sv
design/wrd_ctrl.sv
design/wrd_datapath.sv
design/weather_record_decoder.sv
design/wrd_checker.sv
bench/wrd_checker.sv
bench/tb_weather_record_decoder.sv
